// File: rtl/core/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// shared constants and pipeline stage types for the scattering phase block
// ----------------------------------------------------------------------------
`default_nettype none

package asp_pkg;

    localparam int DIR_FRAC_BITS   = 14;
    localparam int COLOR_FRAC_BITS = 12;
    localparam int SQRT_STEPS      = 16;
    localparam int DIV_STEPS       = 39;

    localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;
    localparam logic [27:0] RAY_K_Q32   = 28'd256336978;
    localparam logic [38:0] PHASE_MAX   = {39{1'b1}};
    localparam logic [19:0] OUT_MAX     = 20'hFFFFF;

    localparam logic [7:0] REG_ANISOTROPY    = 8'd0;
    localparam logic [7:0] REG_SCATTER_RED   = 8'd1;
    localparam logic [7:0] REG_SCATTER_GREEN = 8'd2;
    localparam logic [7:0] REG_SCATTER_BLUE  = 8'd3;

    typedef struct packed {
        logic [2:0][15:0] ray;
        logic [2:0][19:0] ms;
    } color_t;

    typedef struct packed {
        logic [2:0][31:0] dp;
        logic [2:0][15:0] ray;
        logic [2:0][31:0] msp;
    } s1_t;

    typedef struct packed {
        logic [15:0] c;
        color_t      col;
    } s2_t;

    typedef struct packed {
        logic [31:0] c2p;
        logic [31:0] gcp;
        logic [31:0] g2p;
        color_t      col;
    } s3_t;

    typedef struct packed {
        logic [14:0] c2;
        logic [17:0] d;
        logic        dle0;
        logic        neg;
        logic [15:0] nabs;
        color_t      col;
    } s4_t;

    typedef struct packed {
        color_t      col;
        logic [29:0] pr;
        logic        dle0;
        logic        neg;
    } side_t;

    typedef struct packed {
        logic [31:0] v;
        logic [31:0] res;
        logic [17:0] d;
        logic [44:0] q;
        side_t       side;
    } sq_t;

    typedef struct packed {
        logic [33:0] den;
        logic [44:0] q;
        side_t       side;
    } dn_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] den;
        logic [38:0] low;
        logic [38:0] quo;
        logic        sat;
        side_t       side;
    } dv_t;

    typedef struct packed {
        logic [2:0][13:0] rterm;
        logic [2:0][26:0] mterm;
        logic             mneg;
    } fin_t;

endpackage

`default_nettype wire

// File: rtl/core/atmospheric_scattering_phase_top.sv
// ----------------------------------------------------------------------------
// atmospheric_scattering_phase_top
// rayleigh plus henyey-greenstein mie phase scattering, one pixel per cycle
// ----------------------------------------------------------------------------
// stages in order are s1 to s4, the square root stages, dn, the divide stages, fin, output
// throughput: one pixel per cycle while the skid stage is empty; the 16
// square root stages and the 39 restoring divide stages do one step each
// a one-entry skid stage behind the output register keeps the pipe moving
// reset clears all valid bits and loads the register reset values
`default_nettype none

module atmospheric_scattering_phase_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ray_x, ray_y, ray_z, sun_x, sun_y, sun_z, rayleigh_red, rayleigh_green,
    // rayleigh_blue, mie_red, mie_green, mie_blue
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // light_red, light_green, light_blue, zero fill
    output logic [63:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import asp_pkg::*;

    logic [15:0]       aniso_reg;
    logic [2:0][15:0]  scat_reg;

    logic              en;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    s1_t               s1_reg, s1_next;
    s2_t               s2_reg, s2_next;
    s3_t               s3_reg, s3_next;
    s4_t               s4_reg, s4_next;
    logic              sq_valid_reg [0:SQRT_STEPS];
    sq_t               sq_reg       [0:SQRT_STEPS];
    sq_t               sq_next      [0:SQRT_STEPS];
    logic              dn_valid_reg;
    dn_t               dn_reg, dn_next;
    logic              dv_valid_reg [0:DIV_STEPS];
    dv_t               dv_reg       [0:DIV_STEPS];
    dv_t               dv_next      [0:DIV_STEPS];
    logic              fin_valid_reg;
    fin_t              fin_reg, fin_next;
    logic [59:0]       res_data;

    logic              out_valid_reg, skid_valid_reg;
    logic [59:0]       out_data_reg, skid_data_reg;
    logic              take;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign take      = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_data_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aniso_reg <= '0;
            scat_reg  <= {3{16'd4096}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ANISOTROPY:    aniso_reg   <= cfg_data;
                REG_SCATTER_RED:   scat_reg[0] <= cfg_data;
                REG_SCATTER_GREEN: scat_reg[1] <= cfg_data;
                REG_SCATTER_BLUE:  scat_reg[2] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // dot products and mie colour products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_next.dp[i]  = 32'($signed(s_tdata[16*i +: 16]) * $signed(s_tdata[16*(i+3) +: 16]));
            s1_next.ray[i] = s_tdata[16*(i+6) +: 16];
            s1_next.msp[i] = 32'(s_tdata[16*(i+9) +: 16]) * 32'(scat_reg[i]);
        end
    end

    // cos with floor shift and clamp
    always_comb
    begin
        logic signed [33:0] dot;
        logic signed [33:0] cd;
        dot = $signed({{2{s1_reg.dp[0][31]}}, s1_reg.dp[0]})
            + $signed({{2{s1_reg.dp[1][31]}}, s1_reg.dp[1]})
            + $signed({{2{s1_reg.dp[2][31]}}, s1_reg.dp[2]});
        cd  = dot >>> DIR_FRAC_BITS;
        if (cd > 34'sd16384)
            s2_next.c = 16'sd16384;
        else if (cd < -34'sd16384)
            s2_next.c = -16'sd16384;
        else
            s2_next.c = cd[15:0];
        for (int i = 0; i < 3; i++)
        begin
            s2_next.col.ray[i] = s1_reg.ray[i];
            s2_next.col.ms[i]  = s1_reg.msp[i][31:COLOR_FRAC_BITS];
        end
    end

    // cos^2, g*cos, g^2
    always_comb
    begin
        s3_next.c2p = 32'($signed(s2_reg.c) * $signed(s2_reg.c));
        s3_next.gcp = 32'($signed(aniso_reg) * $signed(s2_reg.c));
        s3_next.g2p = 32'($signed(aniso_reg) * $signed(aniso_reg));
        s3_next.col = s2_reg.col;
    end

    // denominator and numerator of the mie phase
    always_comb
    begin
        logic [16:0]        g2;
        logic [17:0]        gc;
        logic signed [19:0] d20;
        logic signed [18:0] num;
        g2  = s3_reg.g2p[30:14];
        gc  = s3_reg.gcp[31:14];
        d20 = 20'sd16384 + $signed({3'b000, g2}) - $signed({gc[17], gc, 1'b0});
        num = 19'sd16384 - $signed({2'b00, g2});
        s4_next.c2   = s3_reg.c2p[28:14];
        s4_next.d    = d20[17:0];
        s4_next.dle0 = d20[19] || (d20 == 20'sd0);
        s4_next.neg  = num[18];
        s4_next.nabs = num[18] ? 16'(-num) : 16'(num);
        s4_next.col  = s3_reg.col;
    end

    // rayleigh phase, mie numerator product, square root operand,
    // then square root, one result bit per stage
    always_comb
    begin
        logic [15:0] opc;
        logic [43:0] prf;
        logic [32:0] t;
        logic [31:0] b;
        opc = 16'(s4_reg.c2) + 16'd16384;
        prf = 44'(opc) * 44'(RAY_K_Q32);
        sq_next[0].v         = {s4_reg.d, 14'b0};
        sq_next[0].res       = '0;
        sq_next[0].d         = s4_reg.d;
        sq_next[0].q         = 45'(s4_reg.nabs) * 45'(INV_4PI_Q32);
        sq_next[0].side.col  = s4_reg.col;
        sq_next[0].side.pr   = prf[43:14];
        sq_next[0].side.dle0 = s4_reg.dle0;
        sq_next[0].side.neg  = s4_reg.neg;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            b = 32'h4000_0000 >> (2 * k);
            t = {1'b0, sq_reg[k].res} + {1'b0, b};
            sq_next[k+1] = sq_reg[k];
            if ({1'b0, sq_reg[k].v} >= t)
            begin
                sq_next[k+1].v   = sq_reg[k].v - t[31:0];
                sq_next[k+1].res = (sq_reg[k].res >> 1) + b;
            end
            else
                sq_next[k+1].res = sq_reg[k].res >> 1;
        end
    end

    always_comb
    begin
        dn_next.den  = 34'(sq_reg[SQRT_STEPS].d) * 34'(sq_reg[SQRT_STEPS].res[15:0]);
        dn_next.q    = sq_reg[SQRT_STEPS].q;
        dn_next.side = sq_reg[SQRT_STEPS].side;
    end

    // divide set-up with overflow check, then restoring steps
    always_comb
    begin
        logic [34:0] r2;
        logic        sat;
        sat = {14'b0, dn_reg.q[44:25]} >= dn_reg.den;
        dv_next[0].sat  = sat;
        dv_next[0].rem  = sat ? 34'd0 : {14'b0, dn_reg.q[44:25]};
        dv_next[0].den  = dn_reg.den;
        dv_next[0].low  = {dn_reg.q[24:0], 14'b0};
        dv_next[0].quo  = '0;
        dv_next[0].side = dn_reg.side;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r2 = {dv_reg[k].rem, dv_reg[k].low[38]};
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].low = {dv_reg[k].low[37:0], 1'b0};
            if (r2 >= {1'b0, dv_reg[k].den})
            begin
                dv_next[k+1].rem = 34'(r2 - {1'b0, dv_reg[k].den});
                dv_next[k+1].quo = {dv_reg[k].quo[37:0], 1'b1};
            end
            else
            begin
                dv_next[k+1].rem = r2[33:0];
                dv_next[k+1].quo = {dv_reg[k].quo[37:0], 1'b0};
            end
        end
    end

    // per channel terms
    always_comb
    begin
        logic [38:0] pm;
        logic [58:0] mp;
        logic [45:0] rp;
        if (dv_reg[DIV_STEPS].side.dle0)
            pm = 39'(INV_4PI_Q32);
        else if (dv_reg[DIV_STEPS].sat)
            pm = PHASE_MAX;
        else
            pm = dv_reg[DIV_STEPS].quo;
        fin_next.mneg = !dv_reg[DIV_STEPS].side.dle0 && dv_reg[DIV_STEPS].side.neg;
        for (int i = 0; i < 3; i++)
        begin
            mp = 59'(dv_reg[DIV_STEPS].side.col.ms[i]) * 59'(pm);
            rp = 46'(dv_reg[DIV_STEPS].side.col.ray[i]) * 46'(dv_reg[DIV_STEPS].side.pr);
            fin_next.mterm[i] = mp[58:32];
            fin_next.rterm[i] = rp[45:32];
        end
    end

    // sum and saturate
    always_comb
    begin
        logic signed [28:0] s;
        for (int i = 0; i < 3; i++)
        begin
            if (fin_reg.mneg)
                s = $signed({15'b0, fin_reg.rterm[i]}) - $signed({2'b0, fin_reg.mterm[i]});
            else
                s = $signed({15'b0, fin_reg.rterm[i]}) + $signed({2'b0, fin_reg.mterm[i]});
            if (s[28])
                res_data[20*i +: 20] = '0;
            else if (s > $signed({9'b0, OUT_MAX}))
                res_data[20*i +: 20] = OUT_MAX;
            else
                res_data[20*i +: 20] = s[19:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            dn_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
                sq_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg    <= s_tvalid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            sq_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            dn_valid_reg    <= sq_valid_reg[SQRT_STEPS];
            dv_valid_reg[0] <= dn_valid_reg;
            for (int k = 0; k < DIV_STEPS; k++)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            fin_valid_reg   <= dv_valid_reg[DIV_STEPS];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            for (int k = 0; k <= SQRT_STEPS; k++)
                sq_reg[k] <= sq_next[k];
            dn_reg <= dn_next;
            for (int k = 0; k <= DIV_STEPS; k++)
                dv_reg[k] <= dv_next[k];
            fin_reg <= fin_next;
        end
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fin_valid_reg)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_valid_reg || take)
                out_data_reg <= skid_data_reg;
        end
        else if (fin_valid_reg)
        begin
            if (!out_valid_reg || take)
                out_data_reg <= res_data;
            else
                skid_data_reg <= res_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (en && fin_valid_reg && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("stalled result not captured in skid stage");

    a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid_reg[SQRT_STEPS] && !sq_reg[SQRT_STEPS].side.dle0)
            |-> (sq_reg[SQRT_STEPS].res[31:16] == 16'd0))
        else $error("square root result wider than 16 bits");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[0] && !dv_reg[0].side.dle0 && !dv_reg[0].sat)
            |-> (dv_reg[0].rem < dv_reg[0].den))
        else $error("partial remainder not below divisor at divide start");

endmodule

`default_nettype wire
